[design/bresl_pkg.sv]
// ----------------------------------------------------------------------------
// Bresenham line raster package
// Shared widths, defaults and request codes for the line pixel generator.
// ----------------------------------------------------------------------------
package bresl_pkg;

    // default coordinate width (range 4 to 16)
    localparam int COORD_BITS_DEFAULT = 8;

    // RGB565 colour word
    localparam int COLOUR_BITS = 16;

    // request codes carried in req_type
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

[design/bresl_if.sv]
// ----------------------------------------------------------------------------
// Bresenham line raster channels
// Request channel (line start or pixel step) and pixel result channel.
// ----------------------------------------------------------------------------
interface bresl_req_if #(
    parameter int COORD_BITS = bresl_pkg::COORD_BITS_DEFAULT
);
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [COORD_BITS-1:0]            x_start;
    logic [COORD_BITS-1:0]            y_start;
    logic [COORD_BITS-1:0]            x_end;
    logic [COORD_BITS-1:0]            y_end;
    logic [bresl_pkg::COLOUR_BITS-1:0] line_colour_in;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, line_colour_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, line_colour_in,
        output ready
    );
endinterface

interface bresl_pix_if #(
    parameter int COORD_BITS = bresl_pkg::COORD_BITS_DEFAULT
);
    logic                             valid;
    logic                             ready;
    logic [COORD_BITS-1:0]            pixel_x;
    logic [COORD_BITS-1:0]            pixel_y;
    logic [bresl_pkg::COLOUR_BITS-1:0] pixel_colour;
    logic                             last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
        output ready
    );
endinterface

[design/bresenham_line_raster.sv]
// ----------------------------------------------------------------------------
// Bresenham line raster
// Emits the pixels of a line, one per request, using integer Bresenham with a
// doubled error term. A start request emits the first endpoint; each step
// request emits the next pixel until the second endpoint has been sent.
// ----------------------------------------------------------------------------
// A request's pixel is valid on the output register in the next cycle.
// Throughput: 1 request per cycle unless stalled; the line state advances by one
//   add, compare and increment per step, held in registers between requests.
// A step request while no line runs is taken and produces no pixel.
// Reset: asynchronous, active low; clears the running-line flag, the pixel
//   count and the output valid; the block is idle and ready after reset.
// ----------------------------------------------------------------------------
module bresenham_line_raster #(
    parameter int COORD_BITS = bresl_pkg::COORD_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    bresl_req_if.sink   req,
    bresl_pix_if.source pix
);

    localparam int CW = COORD_BITS;
    localparam int TW = COORD_BITS + 1;  // doubled delta
    localparam int EW = COORD_BITS + 3;  // signed error term

    // line state: cur_x/cur_y hold the last emitted pixel
    logic                  busy_reg,        busy_next;
    logic [CW-1:0]         pixels_left_reg, pixels_left_next;
    logic [CW-1:0]         cur_x_reg,       cur_x_next;
    logic [CW-1:0]         cur_y_reg,       cur_y_next;
    logic [EW-1:0]         error_reg,       error_next;
    logic [TW-1:0]         major_twice_reg, major_twice_next;
    logic [TW-1:0]         minor_twice_reg, minor_twice_next;
    logic                  x_neg_reg,       x_neg_next;
    logic                  y_neg_reg,       y_neg_next;
    logic                  x_major_reg,     x_major_next;
    logic [bresl_pkg::COLOUR_BITS-1:0] colour_reg, colour_next;

    // output register
    logic                  pix_valid_reg,   pix_valid_next;
    logic [CW-1:0]         pix_x_reg,       pix_x_next;
    logic [CW-1:0]         pix_y_reg,       pix_y_next;
    logic [bresl_pkg::COLOUR_BITS-1:0] pix_colour_reg, pix_colour_next;
    logic                  pix_last_reg,    pix_last_next;

    logic                  in_fire;
    logic                  is_start;
    logic                  emit;

    // start decode
    logic                  s_x_neg, s_y_neg, s_x_major;
    logic [CW-1:0]         s_dx, s_dy, s_major, s_minor;
    logic [EW-1:0]         s_error;

    // step decode
    logic                  err_ge;
    logic [CW-1:0]         x_inc, y_inc;
    logic [CW-1:0]         st_x, st_y;
    logic [EW-1:0]         st_error;
    logic [CW-1:0]         pl_dec;

    assign req.ready = !pix_valid_reg || pix.ready;
    assign in_fire   = req.valid && req.ready;
    assign is_start  = (req.req_type == bresl_pkg::REQ_START);
    assign emit      = in_fire && (is_start || busy_reg);

    // deltas and initial decision value for a new line
    always_comb
    begin
        s_x_neg   = (req.x_end < req.x_start);
        s_y_neg   = (req.y_end < req.y_start);
        s_dx      = s_x_neg ? (req.x_start - req.x_end) : (req.x_end - req.x_start);
        s_dy      = s_y_neg ? (req.y_start - req.y_end) : (req.y_end - req.y_start);
        s_x_major = (s_dx > s_dy);
        s_major   = s_x_major ? s_dx : s_dy;
        s_minor   = s_x_major ? s_dy : s_dx;
        s_error   = {2'b00, s_minor, 1'b0} - {3'b000, s_major};
    end

    // one Bresenham step from the last emitted pixel
    always_comb
    begin
        err_ge   = !error_reg[EW-1];
        x_inc    = x_neg_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
        y_inc    = y_neg_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
        st_x     = (x_major_reg || err_ge) ? x_inc : cur_x_reg;
        st_y     = (!x_major_reg || err_ge) ? y_inc : cur_y_reg;
        st_error = error_reg + {2'b00, minor_twice_reg}
                   - (err_ge ? {2'b00, major_twice_reg} : {EW{1'b0}});
        pl_dec   = pixels_left_reg - 1'b1;
    end

    always_comb
    begin
        busy_next        = busy_reg;
        pixels_left_next = pixels_left_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        error_next       = error_reg;
        major_twice_next = major_twice_reg;
        minor_twice_next = minor_twice_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        x_major_next     = x_major_reg;
        colour_next      = colour_reg;

        pix_x_next       = pix_x_reg;
        pix_y_next       = pix_y_reg;
        pix_colour_next  = pix_colour_reg;
        pix_last_next    = pix_last_reg;
        pix_valid_next   = pix_valid_reg && !pix.ready;

        if (in_fire && is_start)
        begin
            busy_next        = (s_major != '0);
            pixels_left_next = s_major;
            cur_x_next       = req.x_start;
            cur_y_next       = req.y_start;
            error_next       = s_error;
            major_twice_next = {s_major, 1'b0};
            minor_twice_next = {s_minor, 1'b0};
            x_neg_next       = s_x_neg;
            y_neg_next       = s_y_neg;
            x_major_next     = s_x_major;
            colour_next      = req.line_colour_in;

            pix_x_next       = req.x_start;
            pix_y_next       = req.y_start;
            pix_colour_next  = req.line_colour_in;
            pix_last_next    = (s_major == '0);
        end
        else if (emit)
        begin
            busy_next        = (pl_dec != '0);
            pixels_left_next = pl_dec;
            cur_x_next       = st_x;
            cur_y_next       = st_y;
            error_next       = st_error;

            pix_x_next       = st_x;
            pix_y_next       = st_y;
            pix_colour_next  = colour_reg;
            pix_last_next    = (pl_dec == '0);
        end

        if (emit)
        begin
            pix_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            pixels_left_reg <= '0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            pixels_left_reg <= pixels_left_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        error_reg       <= error_next;
        major_twice_reg <= major_twice_next;
        minor_twice_reg <= minor_twice_next;
        x_neg_reg       <= x_neg_next;
        y_neg_reg       <= y_neg_next;
        x_major_reg     <= x_major_next;
        colour_reg      <= colour_next;
        pix_x_reg       <= pix_x_next;
        pix_y_reg       <= pix_y_next;
        pix_colour_reg  <= pix_colour_next;
        pix_last_reg    <= pix_last_next;
    end

    assign pix.valid        = pix_valid_reg;
    assign pix.pixel_x      = pix_x_reg;
    assign pix.pixel_y      = pix_y_reg;
    assign pix.pixel_colour = pix_colour_reg;
    assign pix.last_pixel   = pix_last_reg;

    // a line runs exactly while pixels remain
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (pixels_left_reg != '0))
        else $error("busy flag disagrees with remaining pixel count");

    // a start transfer puts the first endpoint on the output
    a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_start) |=>
            (pix.valid && pix.pixel_x == $past(req.x_start)
             && pix.pixel_y == $past(req.y_start)))
        else $error("start transfer did not emit the first endpoint");

    // the final step flags the last pixel and ends the line
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_start && busy_reg && pixels_left_reg == 1) |=>
            (pix.valid && pix.last_pixel && !busy_reg))
        else $error("final step did not flag the last pixel");

endmodule

[tb/sv/bresenham_line_raster_tb.sv]
// ----------------------------------------------------------------------------
// Bresenham line raster testbench
// Drives line starts and pixel steps into the raster block. It predicts every
// pixel with its own Bresenham stepper and compares each pixel transfer, field
// by field, against the oldest predicted pixel. It covers directed corner lines,
// random well-formed line sequences mixed with stray steps, and a long output
// stall while requests keep arriving.
// ----------------------------------------------------------------------------
module bresenham_line_raster_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB          = bresl_pkg::COORD_BITS_DEFAULT;
    localparam int COLOUR_BITS = bresl_pkg::COLOUR_BITS;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic                   req_type;
        logic [CB-1:0]          x_start;
        logic [CB-1:0]          y_start;
        logic [CB-1:0]          x_end;
        logic [CB-1:0]          y_end;
        logic [COLOUR_BITS-1:0] colour;
    } line_req_t;

    typedef struct packed {
        logic [CB-1:0]          x;
        logic [CB-1:0]          y;
        logic [COLOUR_BITS-1:0] colour;
        logic                   last;
    } pixel_t;

    logic clk;
    logic rst_n;

    bresl_req_if #(.COORD_BITS(CB)) req_ch ();
    bresl_pix_if #(.COORD_BITS(CB)) pix_ch ();

    bresenham_line_raster #(.COORD_BITS(CB)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pix   (pix_ch)
    );

    // stepper state of the line being drawn
    logic [CB-1:0]          step_x;
    logic [CB-1:0]          step_y;
    int                     steps_left;
    int                     err_acc;
    int                     major2;
    int                     minor2;
    bit                     x_neg;
    bit                     y_neg;
    bit                     x_major;
    logic [COLOUR_BITS-1:0] line_colour;
    bit                     drawing;

    pixel_t expected_pixels[$];
    int     pixel_count;
    int     fail_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_request;
    bit     req_xfer;
    bit     pix_xfer;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit predict_pixel(input line_req_t r, output pixel_t p);
        int dx;
        int dy;
        int major;
        int minor;
        bit last;
        if (r.req_type == bresl_pkg::REQ_START)
        begin
            x_neg   = r.x_end < r.x_start;
            y_neg   = r.y_end < r.y_start;
            dx      = x_neg ? int'(r.x_start) - int'(r.x_end) : int'(r.x_end) - int'(r.x_start);
            dy      = y_neg ? int'(r.y_start) - int'(r.y_end) : int'(r.y_end) - int'(r.y_start);
            x_major = dx > dy;
            major   = x_major ? dx : dy;
            minor   = x_major ? dy : dx;
            major2  = 2 * major;
            minor2  = 2 * minor;
            err_acc = minor2 - major;
            step_x  = r.x_start;
            step_y  = r.y_start;
            line_colour = r.colour;
            steps_left  = major;
        end
        else if (!drawing)
            return 1'b0;
        else
            steps_left--;
        last = (steps_left == 0);
        p = '{x: step_x, y: step_y, colour: line_colour, last: last};
        drawing = !last;
        // hold the coordinates on the final pixel so they stay inside the box
        if (!last)
        begin
            if (err_acc >= 0)
            begin
                err_acc -= major2;
                if (x_major)
                    step_y = y_neg ? step_y - 1'b1 : step_y + 1'b1;
                else
                    step_x = x_neg ? step_x - 1'b1 : step_x + 1'b1;
            end
            err_acc += minor2;
            if (x_major)
                step_x = x_neg ? step_x - 1'b1 : step_x + 1'b1;
            else
                step_y = y_neg ? step_y - 1'b1 : step_y + 1'b1;
        end
        return 1'b1;
    endfunction

    // Called and returns on a falling edge.
    task automatic send_req(input line_req_t r);
        pixel_t p;
        // idle while fresh draws fall below send_idle_pct, so the idle share matches it
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid          = 1'b1;
        req_ch.req_type       = r.req_type;
        req_ch.x_start        = r.x_start;
        req_ch.y_start        = r.y_start;
        req_ch.x_end          = r.x_end;
        req_ch.y_end          = r.y_end;
        req_ch.line_colour_in = r.colour;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (predict_pixel(r, p))
        begin
            expected_pixels.push_back(p);
            pixel_count++;
        end
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic start_line(input int x0, input int y0, input int x1, input int y1,
                              input logic [COLOUR_BITS-1:0] colour);
        line_req_t r;
        r = '{req_type: bresl_pkg::REQ_START, x_start: x0[CB-1:0], y_start: y0[CB-1:0],
              x_end: x1[CB-1:0], y_end: y1[CB-1:0], colour: colour};
        send_req(r);
    endtask

    task automatic step_line(input int n);
        line_req_t   r;
        logic [63:0] noise;
        repeat (n)
        begin
            noise = {$urandom, $urandom};
            r = noise[$bits(line_req_t)-1:0];
            r.req_type = bresl_pkg::REQ_STEP;
            send_req(r);
        end
    endtask

    function automatic int near_coord(input int c, input int span);
        int v;
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    task automatic test_directed();
        // step before any line, then single points at both corners
        step_line(1);
        start_line(0, 0, 0, 0, 16'h0000);
        start_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
        step_line(1);
        // equal deltas, cut short by a restart
        start_line(0, 0, COORD_MAX, COORD_MAX, 16'hA5A5);
        step_line(3);
        start_line(COORD_MAX, 0, 0, 3, 16'h5A5A);
        step_line(4);
        // steep short line run to its end, plus one stray step
        start_line(5, COORD_MAX - 5, 3, COORD_MAX, 16'h0F0F);
        step_line(6);
        start_line(0, COORD_MAX, COORD_MAX, COORD_MAX - 1, 16'hF0F0);
        step_line(2);
    endtask

    task automatic test_random_lines(input int n_pixels);
        int target;
        int x0;
        int y0;
        int x1;
        int y1;
        int span;
        int major;
        int roll;
        target = pixel_count + n_pixels;
        while (pixel_count < target)
        begin
            if ($urandom_range(99) < 8)
                step_line($urandom_range(1, 3));
            else
            begin
                x0   = $urandom_range(COORD_MAX);
                y0   = $urandom_range(COORD_MAX);
                span = ($urandom_range(19) == 0) ? COORD_MAX : $urandom_range(0, 12);
                x1   = (span == COORD_MAX) ? $urandom_range(COORD_MAX) : near_coord(x0, span);
                y1   = (span == COORD_MAX) ? $urandom_range(COORD_MAX) : near_coord(y0, span);
                start_line(x0, y0, x1, y1, COLOUR_BITS'($urandom));
                major = (x1 > x0 ? x1 - x0 : x0 - x1);
                if ((y1 > y0 ? y1 - y0 : y0 - y1) > major)
                    major = (y1 > y0 ? y1 - y0 : y0 - y1);
                roll = $urandom_range(99);
                if (roll < 75)
                    step_line(major);
                else if (roll < 90)
                    step_line($urandom_range(0, major));
                else
                    step_line(major + $urandom_range(1, 3));
            end
        end
    endtask

    task automatic test_output_stall();
        // hold the pixel side off so the block fills and blocks its input
        hold_request = 150;
        start_line(0, 0, 40, 17, 16'h1234);
        step_line(40);
    endtask

    // pixel receiver: random idling plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left    = 0;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pix_ch.ready = 1'b0;
                hold_left--;
            end
            else
                pix_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // pixel checker
    always @(posedge clk)
    begin
        pixel_t want;
        req_xfer = rst_n && req_ch.valid && req_ch.ready;
        pix_xfer = rst_n && pix_ch.valid && pix_ch.ready;
        if (pix_xfer)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel transfer x=%0d y=%0d", pix_ch.pixel_x, pix_ch.pixel_y);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pix_ch.pixel_x !== want.x)
                begin
                    $error("pixel_x expected %0d actual %0d", want.x, pix_ch.pixel_x);
                    fail_count++;
                end
                if (pix_ch.pixel_y !== want.y)
                begin
                    $error("pixel_y expected %0d actual %0d", want.y, pix_ch.pixel_y);
                    fail_count++;
                end
                if (pix_ch.pixel_colour !== want.colour)
                begin
                    $error("pixel_colour expected %h actual %h", want.colour,
                           pix_ch.pixel_colour);
                    fail_count++;
                end
                if (pix_ch.last_pixel !== want.last)
                begin
                    $error("last_pixel expected %b actual %b", want.last, pix_ch.last_pixel);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            #1;
            if (req_xfer || pix_xfer)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = bresl_pkg::REQ_START;
        req_ch.x_start        = '0;
        req_ch.y_start        = '0;
        req_ch.x_end          = '0;
        req_ch.y_end          = '0;
        req_ch.line_colour_in = '0;
        drawing       = 1'b0;
        step_x        = '0;
        step_y        = '0;
        steps_left    = 0;
        err_acc       = 0;
        major2        = 0;
        minor2        = 0;
        x_neg         = 1'b0;
        y_neg         = 1'b0;
        x_major       = 1'b0;
        line_colour   = '0;
        pixel_count   = 0;
        fail_count    = 0;
        hold_request  = 0;
        req_xfer      = 1'b0;
        pix_xfer      = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 49;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_lines(530);
        test_output_stall();

        send_idle_pct = 49;
        recv_idle_pct = 9;
        test_random_lines(530);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(530);

        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[bresenham_line_raster.f]
design/bresl_pkg.sv
design/bresl_if.sv
design/bresenham_line_raster.sv
tb/sv/bresenham_line_raster_tb.sv
